@@ design/fct_pkg.sv @@
// Package for the view-volume cull block: plane count, register codes and item types.
// Used by the input channel interface, the config bank, the plane unit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package fct_pkg;

    // Planes requested by the integration and planes that have a register.
    localparam int NUM_PLANES    = 5;
    localparam int PLANE_REGS    = 5;
    localparam int ACTIVE_PLANES = (NUM_PLANES < PLANE_REGS) ? NUM_PLANES : PLANE_REGS;

    localparam int COORD_W   = 16;
    localparam int PLANE_W   = 64;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC_W    = 14;

    localparam logic [PLANE_REGS-1:0] FLAGS_ALL = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLANE_NEAR   = 3'd0,
        CFG_PLANE_LEFT   = 3'd1,
        CFG_PLANE_BOTTOM = 3'd2,
        CFG_PLANE_RIGHT  = 3'd3,
        CFG_PLANE_TOP    = 3'd4,
        CFG_CULL_DIS     = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        OP_SPHERE = 1'b0,
        OP_POINT  = 1'b1
    } t_op;

    typedef struct packed {
        logic [PLANE_REGS-1:0][PLANE_W-1:0] planes;
        logic                               culling_disabled;
    } t_cfg;

    typedef struct packed {
        logic                       op;
        logic signed [COORD_W-1:0]  point_x;
        logic signed [COORD_W-1:0]  point_y;
        logic signed [COORD_W-1:0]  point_z;
        logic        [COORD_W-1:0]  radius;
        logic                       last_point;
    } t_item;

    // Per-plane test result.
    typedef struct packed {
        logic outside;         // distance > 0
        logic beyond_radius;   // distance > radius
    } t_plane_res;

endpackage

`default_nettype wire

@@ design/fct_in_if.sv @@
// Input channel of the cull block: valid/ready handshake plus one test item.
// Depends on fct_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fct_in_if;

    logic                                 valid;
    logic                                 ready;
    logic                                 op;
    logic signed [fct_pkg::COORD_W-1:0]   point_x;
    logic signed [fct_pkg::COORD_W-1:0]   point_y;
    logic signed [fct_pkg::COORD_W-1:0]   point_z;
    logic        [fct_pkg::COORD_W-1:0]   radius;
    logic                                 last_point;

    modport source (
        output valid, op, point_x, point_y, point_z, radius, last_point,
        input  ready
    );

    modport sink (
        input  valid, op, point_x, point_y, point_z, radius, last_point,
        output ready
    );

endinterface

`default_nettype wire

@@ design/fct_out_if.sv @@
// Result channel of the cull block: valid/ready handshake plus the visible flag.
// Stand-alone; no package items needed.
`timescale 1ns / 1ps
`default_nettype none

interface fct_out_if;

    logic valid;
    logic ready;
    logic visible;

    modport source (
        output valid, visible,
        input  ready
    );

    modport sink (
        input  valid, visible,
        output ready
    );

endinterface

`default_nettype wire

@@ design/frustum_cull_test.sv @@
// View-volume cull test for spheres and point sets against near, left, bottom, right, top.
// Each item passes the input register, its result the output register. Throughput: one
// item per cycle unless stalled; set by the single register-to-register pass through
// five parallel plane units (three 16x16 multipliers each) and the sticky flag update.
// Reset (synchronous, active low): pipeline empty, all-outside flags all ones,
// planes cleared to zero and culling disabled.
`timescale 1ns / 1ps
`default_nettype none

module frustum_cull_test (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    fct_in_if.sink                               i_item,
    fct_out_if.source                            o_res,
    input  wire logic                            i_cfg_we,
    input  wire logic [fct_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [fct_pkg::PLANE_W-1:0]     i_cfg_wdata
);

    // ------------------------------------------------------------------
    // Configuration bank. Writes must arrive only while the block is idle;
    // the block does not enforce this, and the plane units read it directly.
    // ------------------------------------------------------------------
    fct_pkg::t_cfg w_cfg;

    fct_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // ------------------------------------------------------------------
    // Input register: holds the item being evaluated this cycle.
    // ------------------------------------------------------------------
    fct_pkg::t_item r_in;
    logic           r_in_valid;

    logic r_out_valid;
    logic r_out_visible;
    logic n_out_visible;

    logic [fct_pkg::PLANE_REGS-1:0] r_flags;
    logic [fct_pkg::PLANE_REGS-1:0] n_flags;

    logic w_produces;   // item in the input register yields a result
    logic w_out_free;   // output register can take a new result
    logic w_advance;    // item in the input register completes this cycle

    assign w_produces = (r_in.op == fct_pkg::OP_SPHERE) || r_in.last_point;
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_advance  = r_in_valid && (w_out_free || !w_produces);

    // Take a new item when the register is empty or the held one completes in this same cycle.
    assign i_item.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    // Payload needs no reset; load on every input transfer.
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.op         <= i_item.op;
            r_in.point_x    <= i_item.point_x;
            r_in.point_y    <= i_item.point_y;
            r_in.point_z    <= i_item.point_z;
            r_in.radius     <= i_item.radius;
            r_in.last_point <= i_item.last_point;
        end
    end

    // ------------------------------------------------------------------
    // Plane units. Planes past the active count have no unit and never
    // report outside, so they never cull.
    // ------------------------------------------------------------------
    logic [fct_pkg::PLANE_REGS-1:0] w_outside;
    logic [fct_pkg::PLANE_REGS-1:0] w_beyond;

    for (genvar p = 0; p < fct_pkg::PLANE_REGS; p++) begin : g_plane
        if (p < fct_pkg::ACTIVE_PLANES) begin : g_active
            fct_pkg::t_plane_res w_pres;

            fct_plane u_plane (
                .i_plane  (w_cfg.planes[p]),
                .i_x      (r_in.point_x),
                .i_y      (r_in.point_y),
                .i_z      (r_in.point_z),
                .i_radius (r_in.radius),
                .o_res    (w_pres)
            );

            assign w_outside[p] = w_pres.outside;
            assign w_beyond[p]  = w_pres.beyond_radius;
        end else begin : g_idle
            assign w_outside[p] = 1'b0;
            assign w_beyond[p]  = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result and sticky flag logic.
    // Sphere: visible unless culling is on, the radius is nonzero and some
    // plane has the centre farther out than the radius. Flags untouched.
    // Point: fold (distance > 0) into each flag. On the last point report
    // visible unless a flag survived, then rearm all flags. Flags update
    // even while culling is disabled; only the result is forced.
    // ------------------------------------------------------------------
    logic [fct_pkg::PLANE_REGS-1:0] w_folded;

    assign w_folded = r_flags & w_outside;

    always_comb begin
        n_flags       = r_flags;
        n_out_visible = 1'b1;
        case (r_in.op)
            fct_pkg::OP_SPHERE: begin
                n_out_visible = w_cfg.culling_disabled || (r_in.radius == '0)
                                || !(|w_beyond);
            end
            default: begin
                n_out_visible = w_cfg.culling_disabled || !(|w_folded);
                n_flags       = r_in.last_point ? fct_pkg::FLAGS_ALL : w_folded;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= fct_pkg::FLAGS_ALL;
        end else if (w_advance) begin
            r_flags <= n_flags;
        end
    end

    // ------------------------------------------------------------------
    // Output register: hold the result until the downstream transfer.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_produces) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_produces) begin
            r_out_visible <= n_out_visible;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.visible = r_out_visible;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_flags_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && (r_in.op == fct_pkg::OP_POINT) && r_in.last_point
        |=> r_flags == fct_pkg::FLAGS_ALL)
        else $error("flags not rearmed after last point");

    a_no_result_mid_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && (r_in.op == fct_pkg::OP_POINT) && !r_in.last_point && w_out_free
        |=> !r_out_valid)
        else $error("result produced by a point that is not last");

    a_zero_radius_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && (r_in.op == fct_pkg::OP_SPHERE) && (r_in.radius == '0)
        |=> r_out_valid && r_out_visible)
        else $error("zero radius sphere culled");

    a_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in))
        else $error("stalled item lost from input register");

endmodule

`default_nettype wire

@@ design/fct_cfg_regs.sv @@
// Configuration register bank: five packed planes and the culling-disabled bit.
// Depends on fct_pkg for the register codes and the t_cfg bundle.
`timescale 1ns / 1ps
`default_nettype none

module fct_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [fct_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [fct_pkg::PLANE_W-1:0]     i_cfg_wdata,
    output fct_pkg::t_cfg                        o_cfg
);

    fct_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.planes           <= '0;
            r_cfg.culling_disabled <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx) inside
                fct_pkg::CFG_PLANE_NEAR, fct_pkg::CFG_PLANE_LEFT,
                fct_pkg::CFG_PLANE_BOTTOM, fct_pkg::CFG_PLANE_RIGHT,
                fct_pkg::CFG_PLANE_TOP: begin
                    r_cfg.planes[i_cfg_idx] <= i_cfg_wdata;
                end
                fct_pkg::CFG_CULL_DIS: begin
                    r_cfg.culling_disabled <= i_cfg_wdata[0];
                end
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ design/fct_plane.sv @@
// One plane test: Q1.14 dot product, floor shift, offset add, sign and radius compares.
// Depends on fct_pkg for widths and the t_plane_res result type.
`timescale 1ns / 1ps
`default_nettype none

module fct_plane (
    input  wire logic        [fct_pkg::PLANE_W-1:0]   i_plane,
    input  wire logic signed [fct_pkg::COORD_W-1:0]   i_x,
    input  wire logic signed [fct_pkg::COORD_W-1:0]   i_y,
    input  wire logic signed [fct_pkg::COORD_W-1:0]   i_z,
    input  wire logic        [fct_pkg::COORD_W-1:0]   i_radius,
    output fct_pkg::t_plane_res                       o_res
);

    localparam int PROD_W = 2 * fct_pkg::COORD_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int Q_W    = SUM_W - fct_pkg::FRAC_W;
    localparam int DIST_W = Q_W + 1;
    localparam int CMP_W  = DIST_W + 1;

    logic signed [fct_pkg::COORD_W-1:0] w_nx, w_ny, w_nz, w_off;
    logic signed [PROD_W-1:0]           w_px, w_py, w_pz;
    logic signed [SUM_W-1:0]            w_sum;
    logic signed [Q_W-1:0]              w_q;
    logic signed [DIST_W-1:0]           w_dist;
    logic signed [CMP_W-1:0]            w_dist_x, w_rad;

    assign w_nx  = i_plane[15:0];
    assign w_ny  = i_plane[31:16];
    assign w_nz  = i_plane[47:32];
    assign w_off = i_plane[63:48];

    assign w_px = PROD_W'(w_nx) * PROD_W'(i_x);
    assign w_py = PROD_W'(w_ny) * PROD_W'(i_y);
    assign w_pz = PROD_W'(w_nz) * PROD_W'(i_z);

    assign w_sum = SUM_W'(w_px) + SUM_W'(w_py) + SUM_W'(w_pz);

    // Dropping the fraction bits of a two's complement sum rounds toward minus infinity.
    assign w_q    = w_sum[SUM_W-1:fct_pkg::FRAC_W];
    assign w_dist = DIST_W'(w_q) + DIST_W'(w_off);

    assign w_dist_x = CMP_W'(w_dist);
    assign w_rad    = $signed({{(CMP_W-fct_pkg::COORD_W){1'b0}}, i_radius});

    assign o_res.outside       = !w_dist[DIST_W-1] && (|w_dist);
    assign o_res.beyond_radius = w_dist_x > w_rad;

endmodule

`default_nettype wire

@@ tb/sv/tb_frustum_cull_test.sv @@
// Self-checking bench for frustum_cull_test: spheres and point sets against five view planes.
// Depends on fct_pkg, fct_in_if and fct_out_if; holds its own cycle-free predictor.
`timescale 1ns / 1ps

module tb_frustum_cull_test;

    import fct_pkg::*;

    // Longest legal quiet stretch: receiver hold-off plus a long gap on each side
    // plus a config burst and settle; take it several times over.
    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 150;
    localparam int MAX_REPORTS = 50;
    localparam int PHASE_ITEMS = 105;

    typedef enum int {
        MIX_BOX_FIXED,
        MIX_BOX_RAND,
        MIX_RANDOM,
        MIX_ONES,
        MIX_MAX,
        MIX_MIN
    } t_plane_mix;

    // One pending transfer: the item, and whether the sender drains the block before offering it.
    typedef struct {
        t_item it;
        bit    drain;
    } t_queued;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [PLANE_W-1:0]    i_cfg_wdata;

    fct_in_if  item_if ();
    fct_out_if res_if ();

    frustum_cull_test DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_if),
        .o_res       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Predictor copy of the block's configuration and sticky flags.
    logic [PLANE_W-1:0]    plane_cfg [PLANE_REGS] = '{default: '0};
    bit                    cull_off = 1'b1;
    logic [PLANE_REGS-1:0] outside_mask = FLAGS_ALL;

    t_queued item_q [$];
    bit      expected_visible_q [$];

    // Traffic shaping knobs, set per phase by the stimulus process.
    bit src_idle_en = 1'b1;
    bit snk_idle_en = 1'b1;
    int hold_req    = 0;

    // Shared between the monitor (writes at posedge) and the driver (reads at negedge).
    bit in_took = 1'b0;

    int      mismatches    = 0;
    int      n_items       = 0;
    int      n_results     = 0;
    int      n_culled      = 0;
    int      n_sets        = 0;
    int      n_cfg_phases  = 0;
    int      quiet_cycles  = 0;
    int      src_gap       = 0;
    int      snk_gap       = 0;
    int      hold_ack      = 0;
    int      hold_left     = 0;
    t_queued cur_item;
    t_item   seen_item;
    bit      seen_vis;
    bit      exp_vis;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic int rand_between(int lo, int hi);
        return int'($urandom_range(0, hi - lo)) + lo;
    endfunction

    // Mostly back-to-back, often a short gap, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [PLANE_W-1:0] pack_plane(int nx, int ny, int nz, int off);
        return {16'(off), 16'(nz), 16'(ny), 16'(nx)};
    endfunction

    // Box-shaped volumes use axis normals of magnitude 1.0 (16384 in Q1.14): near faces +z,
    // the sides bound x and y at +/- half.
    function automatic logic [PLANE_W-1:0] plane_word(t_plane_mix mix, int p);
        int half;
        int near_off;
        half     = (mix == MIX_BOX_FIXED) ? 1000 : rand_between(0, 20000);
        near_off = (mix == MIX_BOX_FIXED) ? 100 : rand_between(-2000, 2000);
        case (mix)
            MIX_BOX_FIXED, MIX_BOX_RAND: begin
                case (t_cfg_idx'(p))
                    CFG_PLANE_NEAR:   return pack_plane(0, 0, -16384, near_off);
                    CFG_PLANE_LEFT:   return pack_plane(-16384, 0, 0, -half);
                    CFG_PLANE_BOTTOM: return pack_plane(0, -16384, 0, -half);
                    CFG_PLANE_RIGHT:  return pack_plane(16384, 0, 0, -half);
                    default:          return pack_plane(0, 16384, 0, -half);
                endcase
            end
            MIX_RANDOM: begin
                return pack_plane(rand_between(-16384, 16384), rand_between(-16384, 16384),
                                  rand_between(-16384, 16384), rand_between(-32768, 32767));
            end
            MIX_ONES: return '1;
            MIX_MAX:  return {4{16'h7FFF}};
            default:  return {4{16'h8000}};
        endcase
    endfunction

    function automatic void queue_item(t_op op, int x, int y, int z, int r, bit last,
                                       bit drain = 1'b0);
        t_queued q;
        q.it.op         = op;
        q.it.point_x    = 16'(x);
        q.it.point_y    = 16'(y);
        q.it.point_z    = 16'(z);
        q.it.radius     = 16'(r);
        q.it.last_point = last;
        q.drain         = drain;
        item_q.push_back(q);
    endfunction

    // Signed distance: floor(n . P / 2^14) + offset. Arithmetic shift gives the floor.
    function automatic longint plane_distance(int p, t_item it);
        logic signed [15:0] nx, ny, nz, off, px, py, pz;
        longint acc;
        {off, nz, ny, nx} = plane_cfg[p];
        px  = it.point_x;
        py  = it.point_y;
        pz  = it.point_z;
        acc = longint'(nx) * longint'(px) + longint'(ny) * longint'(py)
            + longint'(nz) * longint'(pz);
        return (acc >>> FRAC_W) + longint'(off);
    endfunction

    // Test a sphere, or fold a point into the sticky flags; return 1 when the item produces a visibility result.
    function automatic bit predict_visibility(t_item it, output bit vis);
        longint rad;
        bit     culled;
        rad    = longint'({48'd0, it.radius});
        culled = 1'b0;
        if (it.op == OP_SPHERE) begin
            if (!cull_off && it.radius != 0) begin
                for (int p = 0; p < ACTIVE_PLANES; p++) begin
                    if (plane_distance(p, it) > rad) culled = 1'b1;
                end
            end
            vis = !culled;
            return 1'b1;
        end
        // Clear a plane's flag as soon as one point lies on it or on its inner side.
        for (int p = 0; p < PLANE_REGS; p++) begin
            if (!(p < ACTIVE_PLANES && plane_distance(p, it) > 0)) outside_mask[p] = 1'b0;
        end
        if (!it.last_point) return 1'b0;
        vis          = cull_off || (outside_mask == '0);
        outside_mask = FLAGS_ALL;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, bit want, logic got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s: expected visible=%0b, got %b", $realtime, what, want, got);
    endtask

    // Wait until the block holds nothing: queue drained, no offer, no result outstanding.
    // Points that end no set produce no result, so a final wait lets the pipeline empty.
    task automatic settle();
        while (item_q.size() != 0 || item_if.valid || expected_visible_q.size() != 0)
            @(posedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // One register write, then drop the enable. Update the predictor copy in step.
    task automatic write_reg(t_cfg_idx idx, logic [PLANE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        if (idx == CFG_CULL_DIS) cull_off = val[0];
        else plane_cfg[int'(idx)] = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_config(t_plane_mix mix, bit dis);
        settle();
        for (int p = 0; p < PLANE_REGS; p++) write_reg(t_cfg_idx'(p), plane_word(mix, p));
        write_reg(CFG_CULL_DIS, PLANE_W'(dis));
        n_cfg_phases++;
    endtask

    // Random traffic: mostly well-formed point sets around a cluster centre and spheres,
    // with some noise that breaks set boundaries. The 51st item drains the block first.
    task automatic gen_phase(int n_wanted);
        int made, roll, len, cx, cy, cz, spread;
        made = 0;
        while (made < n_wanted) begin
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                roll = $urandom_range(0, 9);
                spread = (roll == 0) ? 0 : (roll < 4) ? rand_between(0, 200) :
                         (roll < 7) ? rand_between(0, 5000) : rand_between(0, 65535);
                roll = $urandom_range(0, 1);
                cx = roll ? rand_between(-3000, 3000) : rand_between(-32768, 32767);
                cy = roll ? rand_between(-3000, 3000) : rand_between(-32768, 32767);
                cz = roll ? rand_between(-3000, 3000) : rand_between(-32768, 32767);
                queue_item(OP_SPHERE, cx, cy, cz, spread, 1'($urandom_range(0, 1)),
                           made == 50);
                made++;
            end else if (roll < 85) begin
                len    = $urandom_range(1, 8);
                cx     = rand_between(-20000, 20000);
                cy     = rand_between(-20000, 20000);
                cz     = rand_between(-20000, 20000);
                spread = ($urandom_range(0, 1) != 0) ? rand_between(0, 300)
                                                     : rand_between(0, 8000);
                for (int k = 0; k < len; k++) begin
                    queue_item(OP_POINT, cx + rand_between(-spread, spread),
                               cy + rand_between(-spread, spread),
                               cz + rand_between(-spread, spread),
                               rand_between(0, 65535), k == len - 1, made == 50);
                    made++;
                end
            end else begin
                queue_item(t_op'($urandom_range(0, 1)), rand_between(-32768, 32767),
                           rand_between(-32768, 32767), rand_between(-32768, 32767),
                           rand_between(0, 65535), 1'($urandom_range(0, 1)), made == 50);
                made++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Driver: offer the head of item_q at the falling edge; hold it until the transfer.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!item_if.valid || in_took)) begin
            // A transfer just happened: draw the idle gap before the next offer.
            if (item_if.valid && src_idle_en) src_gap = pick_gap();
            if (src_gap > 0) begin
                src_gap--;
                item_if.valid <= 1'b0;
            end else if (item_q.size() != 0
                         && !(item_q[0].drain && expected_visible_q.size() != 0)) begin
                cur_item = item_q.pop_front();
                item_if.op         <= cur_item.it.op;
                item_if.point_x    <= cur_item.it.point_x;
                item_if.point_y    <= cur_item.it.point_y;
                item_if.point_z    <= cur_item.it.point_z;
                item_if.radius     <= cur_item.it.radius;
                item_if.last_point <= cur_item.it.last_point;
                item_if.valid      <= 1'b1;
            end else begin
                item_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request, counted here.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_ack != hold_req) begin
            hold_ack++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
            if (snk_idle_en) snk_gap = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check result transfers first, then predict for the input transfer.
    // A result never comes out in the same cycle as its own input, so the order is safe.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_took = i_rst_n && item_if.valid && item_if.ready;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            n_results++;
            if (expected_visible_q.size() == 0) begin
                report_mismatch("result with nothing pending", 1'b0, res_if.visible);
            end else begin
                exp_vis = expected_visible_q.pop_front();
                if (res_if.visible !== exp_vis)
                    report_mismatch("visible flag wrong", exp_vis, res_if.visible);
            end
        end
        if (in_took) begin
            n_items++;
            seen_item.op         = item_if.op;
            seen_item.point_x    = item_if.point_x;
            seen_item.point_y    = item_if.point_y;
            seen_item.point_z    = item_if.point_z;
            seen_item.radius     = item_if.radius;
            seen_item.last_point = item_if.last_point;
            if (predict_visibility(seen_item, seen_vis)) begin
                expected_visible_q.push_back(seen_vis);
                if (!seen_vis) n_culled++;
                if (seen_item.op == OP_POINT) n_sets++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when nothing moves for too long.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) || i_cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_visible_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        // Drive every input to a known value before the first edge.
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_PLANE_NEAR;
        i_cfg_wdata        = '0;
        item_if.valid      = 1'b0;
        item_if.op         = OP_SPHERE;
        item_if.point_x    = '0;
        item_if.point_y    = '0;
        item_if.point_z    = '0;
        item_if.radius     = '0;
        item_if.last_point = 1'b0;
        res_if.ready       = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Out of reset culling is off: everything must come back visible.
        queue_item(OP_SPHERE, 32767, 32767, 32767, 5, 1'b0);
        queue_item(OP_POINT, -32768, -32768, -32768, 0, 1'b0);
        queue_item(OP_POINT, -32768, -32768, -32768, 0, 1'b1);

        // Fixed box: |x| <= 1000, |y| <= 1000, z >= 100.
        apply_config(MIX_BOX_FIXED, 1'b0);
        queue_item(OP_SPHERE, 0, 0, 500, 10, 1'b0);            // inside
        queue_item(OP_SPHERE, 5000, 0, 500, 10, 1'b0);         // beyond the right plane
        queue_item(OP_SPHERE, 5000, 0, 500, 0, 1'b0);          // zero radius always passes
        queue_item(OP_SPHERE, 5000, 0, 500, 65535, 1'b0);      // huge radius reaches in
        queue_item(OP_SPHERE, -32768, -32768, -32768, 1, 1'b1); // corner; last mark ignored
        queue_item(OP_SPHERE, 32767, 32767, 32767, 65535, 1'b0);
        queue_item(OP_SPHERE, 1000, 0, 100, 1, 1'b0);          // exactly on the boundary
        queue_item(OP_POINT, 2000, 0, 500, 65535, 1'b0);       // whole set right of the box
        queue_item(OP_POINT, 3000, 50, 600, 0, 1'b1);
        queue_item(OP_POINT, 2000, 0, 500, 0, 1'b0);           // one point inside
        queue_item(OP_POINT, 0, 0, 500, 0, 1'b1);
        queue_item(OP_POINT, 0, 0, -500, 0, 1'b1);             // single point behind near
        queue_item(OP_POINT, 2000, 0, 500, 0, 1'b0);           // outside different planes
        queue_item(OP_POINT, -2000, 0, 500, 0, 1'b1);

        // Turn culling off in the middle of a set: the result is forced visible.
        queue_item(OP_POINT, 2000, 0, 500, 0, 1'b0);
        settle();
        write_reg(CFG_CULL_DIS, PLANE_W'(1));
        queue_item(OP_POINT, 3000, 0, 500, 0, 1'b1);
        // Start a set while off, finish it after turning culling back on: flags kept counting.
        queue_item(OP_POINT, 2000, 0, 500, 0, 1'b0);
        settle();
        write_reg(CFG_CULL_DIS, PLANE_W'(0));
        queue_item(OP_POINT, 3000, 0, 500, 0, 1'b1);
        queue_item(OP_POINT, 0, 0, 500, 0, 1'b1);              // flags back to all ones

        // Random phases, each with its own plane setup, some with their own traffic shape.
        for (int ph = 0; ph < 8; ph++) begin
            src_idle_en = 1'b1;
            snk_idle_en = 1'b1;
            case (ph)
                0: apply_config(MIX_BOX_RAND, 1'b0);
                1: begin
                    // Back-pressure: keep offering while the receiver holds off.
                    apply_config(MIX_RANDOM, 1'b0);
                    src_idle_en = 1'b0;
                    hold_req++;
                end
                2: apply_config(MIX_RANDOM, 1'b1);
                3: apply_config(MIX_ONES, 1'b0);
                4: apply_config(MIX_MAX, 1'b0);
                5: apply_config(MIX_MIN, 1'b0);
                6: begin
                    // Stretch with no idling on either side.
                    apply_config(MIX_BOX_RAND, 1'b0);
                    src_idle_en = 1'b0;
                    snk_idle_en = 1'b0;
                end
                default: apply_config(MIX_RANDOM, 1'b0);
            endcase
            gen_phase(PHASE_ITEMS);
        end

        // Drain, then give the pipeline its latency plus margin.
        settle();
        repeat (4) @(negedge i_clk);

        $display("Covered %0d item transfers, %0d results checked (%0d culled), %0d point sets,",
                 n_items, n_results, n_culled, n_sets);
        $display("over %0d plane setups including all-ones, max and min register values.",
                 n_cfg_phases);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
